// ===== hw/rtl/nggp_pkg.sv =====
`timescale 1ns / 1ps
package nggp_pkg;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UM     = 8'h4D;
    localparam logic [7:0] CH_UN     = 8'h4E;
    localparam logic [7:0] CH_UP     = 8'h50;
    localparam logic [7:0] CH_UR     = 8'h52;
    localparam logic [7:0] CH_US     = 8'h53;
    localparam logic [7:0] CH_UW     = 8'h57;

    // minutes at or above this always saturate the coordinate
    localparam logic [16:0] WHOLE_BIG = 17'd10800;
    localparam logic [23:0] DEG_SCALE = 24'd10000000;
    localparam logic [34:0] LAT_LIMIT = 35'd900000000;
    localparam logic [34:0] LON_LIMIT = 35'd1800000000;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_GGA  = 2'd1,
        ST_RMC  = 2'd2
    } stype_t;

    typedef enum logic [2:0] {
        R_NONE   = 3'd0,
        R_COORD  = 3'd1,
        R_HLAT   = 3'd2,
        R_HLON   = 3'd3,
        R_QUAL   = 3'd4,
        R_STATUS = 3'd5
    } role_t;

    typedef enum logic [1:0] {
        MP_WHOLE = 2'd0,
        MP_FRAC  = 2'd1,
        MP_DONE  = 2'd2
    } min_phase_t;

    typedef struct packed {
        logic       latch;
        logic       ok;
        logic       hlat;
        logic       hlon;
        logic       one_char;
        logic [7:0] first_char;
    } coord_ctl_t;

    // quotient / remainder of d * 1e7 / 60, one entry per digit
    function automatic logic [9:0][23:0] build_wq();
        logic [9:0][23:0] r;
        for (int i = 0; i < 10; i++) begin
            r[i] = 24'((i * 10000000) / 60);
        end
        return r;
    endfunction

    function automatic logic [9:0][5:0] build_wr();
        logic [9:0][5:0] r;
        for (int i = 0; i < 10; i++) begin
            r[i] = 6'((i * 10000000) % 60);
        end
        return r;
    endfunction

    // fraction digit j (1..7) of the minutes weighs d * 10^(7-j) / 60
    function automatic logic [7:0][9:0][17:0] build_fq();
        logic [7:0][9:0][17:0] r;
        int p;
        r = '0;
        for (int j = 1; j < 8; j++) begin
            p = 1;
            for (int k = 0; k < 7 - j; k++) begin
                p = p * 10;
            end
            for (int i = 0; i < 10; i++) begin
                r[j][i] = 18'((i * p) / 60);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0][9:0][5:0] build_fr();
        logic [7:0][9:0][5:0] r;
        int p;
        r = '0;
        for (int j = 1; j < 8; j++) begin
            p = 1;
            for (int k = 0; k < 7 - j; k++) begin
                p = p * 10;
            end
            for (int i = 0; i < 10; i++) begin
                r[j][i] = 6'((i * p) % 60);
            end
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

endpackage

// ===== hw/rtl/nggp_min_acc.sv =====
`timescale 1ns / 1ps
// Minutes accumulator: keeps minutes * 1e7 as quotient and remainder by 60,
// updated one digit per item.
module nggp_min_acc #(
    parameter int FRAC_DIGITS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        feed,
    input  logic [7:0]  ch,
    output logic [31:0] term,
    output logic        big
);
    import nggp_pkg::*;

    localparam logic [9:0][23:0]      WQ = build_wq();
    localparam logic [9:0][5:0]       WR = build_wr();
    localparam logic [7:0][9:0][17:0] FQ = build_fq();
    localparam logic [7:0][9:0][5:0]  FR = build_fr();

    min_phase_t  phase_reg, phase_next;
    logic [13:0] whole_reg, whole_next;
    logic        big_reg, big_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  r_reg, r_next;
    logic [2:0]  fc_reg, fc_next;

    logic [3:0]  d;
    logic [16:0] w17;
    logic [9:0]  t;
    logic [3:0]  c;
    logic [35:0] q10;
    logic [2:0]  j;
    logic [6:0]  rs;

    assign d = ch[3:0] - CH_ZERO[3:0];

    always_comb
    begin
        phase_next = phase_reg;
        whole_next = whole_reg;
        big_next   = big_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        fc_next    = fc_reg;
        w17 = 17'(whole_reg) * 17'd10 + 17'(d);
        t   = 10'(r_reg) * 10'd10 + 10'(WR[d]);
        c   = '0;
        for (int k = 1; k <= 10; k++) begin
            if (t >= 10'(60 * k)) begin
                c = 4'(k);
            end
        end
        q10 = {q_reg, 3'b000} + {3'b000, q_reg, 1'b0};
        j   = 3'(fc_reg + 3'd1);
        rs  = 7'(r_reg) + 7'(FR[j][d]);
        if (clear)
        begin
            phase_next = MP_WHOLE;
            whole_next = '0;
            big_next   = 1'b0;
            q_next     = '0;
            r_next     = '0;
            fc_next    = '0;
        end
        else if (feed)
        begin
            case (phase_reg)
                MP_WHOLE:
                begin
                    if (is_digit(ch))
                    begin
                        if (!big_reg)
                        begin
                            if (w17 >= WHOLE_BIG)
                            begin
                                big_next = 1'b1;
                            end
                            else
                            begin
                                whole_next = w17[13:0];
                                q_next = 32'(q10) + 32'(WQ[d]) + 32'(c);
                                r_next = 6'(t - 10'(c) * 10'd60);
                            end
                        end
                    end
                    else if (ch == CH_DOT)
                    begin
                        phase_next = MP_FRAC;
                    end
                    else
                    begin
                        phase_next = MP_DONE;
                    end
                end
                MP_FRAC:
                begin
                    if (is_digit(ch))
                    begin
                        if ({1'b0, fc_reg} < 4'(FRAC_DIGITS))
                        begin
                            fc_next = j;
                            if (!big_reg)
                            begin
                                if (rs >= 7'd60)
                                begin
                                    q_next = q_reg + 32'(FQ[j][d]) + 32'd1;
                                    r_next = 6'(rs - 7'd60);
                                end
                                else
                                begin
                                    q_next = q_reg + 32'(FQ[j][d]);
                                    r_next = rs[5:0];
                                end
                            end
                        end
                    end
                    else
                    begin
                        phase_next = MP_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MP_WHOLE;
            whole_reg <= '0;
            big_reg   <= 1'b0;
            q_reg     <= '0;
            r_reg     <= '0;
            fc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            whole_reg <= whole_next;
            big_reg   <= big_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            fc_reg    <= fc_next;
        end
    end

    // round to nearest, halves up
    assign term = q_reg + 32'(r_reg >= 6'd30);
    assign big  = big_reg;

endmodule

// ===== hw/rtl/nggp_coord.sv =====
`timescale 1ns / 1ps
// Latches a coordinate field and turns it into a signed 1e-7 degree value
// when the hemisphere field closes.
module nggp_coord (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nggp_pkg::coord_ctl_t  ctl,
    input  logic [6:0]            deg2,
    input  logic [9:0]            deg3,
    input  logic [31:0]           term2,
    input  logic                  big2,
    input  logic [31:0]           term3,
    input  logic                  big3,
    output logic [31:0]           pending_lat,
    output logic [31:0]           pending_lon
);
    import nggp_pkg::*;

    logic        ok_reg;
    logic [29:0] degs2_reg;
    logic [33:0] degs3_reg;
    logic [31:0] term2_reg, term3_reg;
    logic        big2_reg, big3_reg;
    logic [31:0] plat_reg, plon_reg;

    logic        split3, neg, big;
    logic [34:0] mag, limit, sat;
    logic [31:0] coord;

    always_comb
    begin
        split3 = !(ctl.one_char && (ctl.first_char == CH_UN || ctl.first_char == CH_US));
        neg    = ctl.one_char && (ctl.first_char == CH_US || ctl.first_char == CH_UW);
        limit  = ctl.hlat ? LAT_LIMIT : LON_LIMIT;
        if (split3)
        begin
            mag = 35'(degs3_reg) + 35'(term3_reg);
            big = big3_reg;
        end
        else
        begin
            mag = 35'(degs2_reg) + 35'(term2_reg);
            big = big2_reg;
        end
        sat = (big || mag > limit) ? limit : mag;
        if (!ok_reg)
        begin
            coord = '0;
        end
        else if (neg)
        begin
            coord = 32'(-sat);
        end
        else
        begin
            coord = sat[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg    <= 1'b0;
            degs2_reg <= '0;
            degs3_reg <= '0;
            term2_reg <= '0;
            term3_reg <= '0;
            big2_reg  <= 1'b0;
            big3_reg  <= 1'b0;
            plat_reg  <= '0;
            plon_reg  <= '0;
        end
        else
        begin
            if (ctl.latch)
            begin
                ok_reg    <= ctl.ok;
                degs2_reg <= 30'(deg2) * 30'(DEG_SCALE);
                degs3_reg <= 34'(deg3) * 34'(DEG_SCALE);
                term2_reg <= term2;
                term3_reg <= term3;
                big2_reg  <= big2;
                big3_reg  <= big3;
            end
            if (ctl.hlat)
            begin
                plat_reg <= coord;
            end
            if (ctl.hlon)
            begin
                plon_reg <= coord;
            end
        end
    end

    assign pending_lat = plat_reg;
    assign pending_lon = plon_reg;

endmodule

// ===== hw/rtl/nmea_gga_rmc_position_parser.sv =====
`timescale 1ns / 1ps
// NMEA GGA / RMC position parser.
// Input stream: one received character per item on s_axis_tdata.
// Output stream: one item per accepted $GPGGA or $GPRMC line of at least
// seven fields, issued for the newline byte. tdata carries latitude and
// longitude in 1e-7 degrees (south / west negative, saturated) and the fix
// flag; tuser is the sentence kind (0 GGA, 1 RMC).
// Throughput: one character per cycle when not stalled. Every character is
// decoded in the cycle it is accepted; minutes are kept as quotient and
// remainder by 60, updated one digit per character, so no divider is needed.
// Latency: the result item is valid the cycle after its newline is accepted.
// The output register decouples the sides: input is taken while the output
// is empty or being taken in the same cycle, so a stalled receiver holds the
// pending result and stops input only while that result waits.
// Reset clears the line state, the stored position and the fix flag; the
// output is empty after reset.
module nmea_gga_rmc_position_parser #(
    parameter int FRAC_DIGITS = 5,
    parameter int MAX_FIELDS  = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // latitude[30:0], longitude[62:31], has_fix[63]
    output logic [0:0]  m_axis_tuser    // sentence_kind
);
    import nggp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hpos_reg, hpos_next;
    stype_t      stype_reg, stype_next;
    logic [3:0]  fn_reg, fn_next;
    logic [2:0]  flen_reg, flen_next;
    logic        dot_reg, dot_next;
    logic [7:0]  first_reg, first_next;
    logic        dstop_reg, dstop_next;
    logic [6:0]  deg2_reg, deg2_next;
    logic [9:0]  deg3_reg, deg3_next;
    logic [1:0]  qph_reg, qph_next;
    logic        qneg_reg, qneg_next;
    logic        qnz_reg, qnz_next;
    logic        status_reg, status_next;
    logic        qual_reg, qual_next;
    logic [31:0] lat_reg, lat_next;
    logic [31:0] lon_reg, lon_next;
    logic        fix_reg, fix_next;
    logic        mvalid_reg, mvalid_next;
    logic [63:0] mdata_reg, mdata_next;
    logic        muser_reg, muser_next;

    logic        accept;
    logic [7:0]  c;
    logic [3:0]  d;
    logic        hok;
    logic        clr;
    logic        feed;
    role_t       role;
    coord_ctl_t  cctl;
    logic [31:0] term2, term3, plat, plon;
    logic        big2, big3;

    assign s_axis_tready = !mvalid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign c = s_axis_tdata;
    assign d = c[3:0] - CH_ZERO[3:0];

    always_comb
    begin
        role = R_NONE;
        case (fn_reg)
            4'd2: role = (stype_reg == ST_GGA) ? R_COORD : R_STATUS;
            4'd3: role = (stype_reg == ST_GGA) ? R_HLAT : R_COORD;
            4'd4: role = (stype_reg == ST_GGA) ? R_COORD : R_HLAT;
            4'd5: role = (stype_reg == ST_GGA) ? R_HLON : R_COORD;
            4'd6: role = (stype_reg == ST_GGA) ? R_QUAL : R_HLON;
            default: role = R_NONE;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        stype_next  = stype_reg;
        fn_next     = fn_reg;
        flen_next   = flen_reg;
        dot_next    = dot_reg;
        first_next  = first_reg;
        dstop_next  = dstop_reg;
        deg2_next   = deg2_reg;
        deg3_next   = deg3_reg;
        qph_next    = qph_reg;
        qneg_next   = qneg_reg;
        qnz_next    = qnz_reg;
        status_next = status_reg;
        qual_next   = qual_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        fix_next    = fix_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        clr  = 1'b0;
        feed = 1'b0;
        hok  = 1'b0;
        cctl = '0;
        cctl.ok = (flen_reg >= 3'd6) && dot_reg;
        cctl.one_char = (flen_reg == 3'd1);
        cctl.first_char = first_reg;

        if (accept && c != CH_CR)
        begin
            if (c == CH_NL)
            begin
                if (phase_reg == PH_BODY && fn_reg >= 4'd7)
                begin
                    if (stype_reg == ST_GGA)
                    begin
                        lat_next = plat;
                        lon_next = plon;
                        fix_next = qual_reg;
                    end
                    else if (status_reg)
                    begin
                        lat_next = plat;
                        lon_next = plon;
                        fix_next = 1'b1;
                    end
                    else
                    begin
                        fix_next = 1'b0;
                    end
                    mvalid_next = 1'b1;
                    mdata_next  = {fix_next, lon_next, lat_next[30:0]};
                    muser_next  = (stype_reg == ST_RMC);
                end
                phase_next = PH_START;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (!is_blank(c))
                        begin
                            if (c == CH_DOLLAR)
                            begin
                                phase_next = PH_HEADER;
                                hpos_next  = 3'd1;
                                stype_next = ST_NONE;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_HEADER:
                    begin
                        case (hpos_reg)
                            3'd1: hok = (c == CH_UG);
                            3'd2: hok = (c == CH_UP);
                            3'd3:
                            begin
                                hok = (c == CH_UG) || (c == CH_UR);
                                stype_next = (c == CH_UG) ? ST_GGA :
                                             (c == CH_UR) ? ST_RMC : ST_NONE;
                            end
                            3'd4: hok = (stype_reg == ST_GGA && c == CH_UG) ||
                                        (stype_reg == ST_RMC && c == CH_UM);
                            3'd5: hok = (stype_reg == ST_GGA && c == CH_UA) ||
                                        (stype_reg == ST_RMC && c == CH_UC);
                            default: hok = 1'b0;
                        endcase
                        if (!hok)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            hpos_next = 3'(hpos_reg + 3'd1);
                            if (hpos_reg == 3'd5)
                            begin
                                phase_next = PH_BODY;
                                fn_next = '0;
                                clr = 1'b1;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (fn_reg < 4'(MAX_FIELDS))
                        begin
                            if (c == CH_COMMA || c == CH_STAR)
                            begin
                                case (role)
                                    R_COORD:  cctl.latch = 1'b1;
                                    R_HLAT:   cctl.hlat = 1'b1;
                                    R_HLON:   cctl.hlon = 1'b1;
                                    R_QUAL:   qual_next = qnz_reg && !qneg_reg;
                                    R_STATUS: status_next = (flen_reg == 3'd1) &&
                                                            (first_reg == CH_UA);
                                    default:
                                    begin
                                    end
                                endcase
                                fn_next = 4'(fn_reg + 4'd1);
                                clr = 1'b1;
                            end
                            else
                            begin
                                feed = 1'b1;
                                if (flen_reg == 3'd0)
                                begin
                                    first_next = c;
                                end
                                if (flen_reg != 3'd7)
                                begin
                                    flen_next = 3'(flen_reg + 3'd1);
                                end
                                if (c == CH_DOT)
                                begin
                                    dot_next = 1'b1;
                                end
                                if (flen_reg < 3'd3)
                                begin
                                    if (!dstop_reg && is_digit(c))
                                    begin
                                        if (flen_reg < 3'd2)
                                        begin
                                            deg2_next = 7'(deg2_reg * 7'd10 + 7'(d));
                                        end
                                        deg3_next = 10'(deg3_reg * 10'd10 + 10'(d));
                                    end
                                    else
                                    begin
                                        dstop_next = 1'b1;
                                    end
                                end
                                // quality: blanks, optional sign, then digits
                                if (qph_reg == 2'd0 && is_blank(c))
                                begin
                                end
                                else if (qph_reg == 2'd0 && (c == CH_PLUS || c == CH_MINUS))
                                begin
                                    qneg_next = (c == CH_MINUS);
                                    qph_next  = 2'd1;
                                end
                                else if (qph_reg < 2'd2 && is_digit(c))
                                begin
                                    qph_next = 2'd1;
                                    if (c != CH_ZERO)
                                    begin
                                        qnz_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    qph_next = 2'd2;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (clr)
        begin
            flen_next  = '0;
            dot_next   = 1'b0;
            first_next = '0;
            dstop_next = 1'b0;
            deg2_next  = '0;
            deg3_next  = '0;
            qph_next   = '0;
            qneg_next  = 1'b0;
            qnz_next   = 1'b0;
        end
    end

    nggp_min_acc #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_min2 (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clr),
        .feed  (feed && flen_reg >= 3'd2),
        .ch    (c),
        .term  (term2),
        .big   (big2)
    );

    nggp_min_acc #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_min3 (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clr),
        .feed  (feed && flen_reg >= 3'd3),
        .ch    (c),
        .term  (term3),
        .big   (big3)
    );

    nggp_coord u_coord (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (cctl),
        .deg2        (deg2_reg),
        .deg3        (deg3_reg),
        .term2       (term2),
        .big2        (big2),
        .term3       (term3),
        .big3        (big3),
        .pending_lat (plat),
        .pending_lon (plon)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            hpos_reg   <= '0;
            stype_reg  <= ST_NONE;
            fn_reg     <= '0;
            flen_reg   <= '0;
            dot_reg    <= 1'b0;
            first_reg  <= '0;
            dstop_reg  <= 1'b0;
            deg2_reg   <= '0;
            deg3_reg   <= '0;
            qph_reg    <= '0;
            qneg_reg   <= 1'b0;
            qnz_reg    <= 1'b0;
            status_reg <= 1'b0;
            qual_reg   <= 1'b0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            fix_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            stype_reg  <= stype_next;
            fn_reg     <= fn_next;
            flen_reg   <= flen_next;
            dot_reg    <= dot_next;
            first_reg  <= first_next;
            dstop_reg  <= dstop_next;
            deg2_reg   <= deg2_next;
            deg3_reg   <= deg3_next;
            qph_reg    <= qph_next;
            qneg_reg   <= qneg_next;
            qnz_reg    <= qnz_next;
            status_reg <= status_next;
            qual_reg   <= qual_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            fix_reg    <= fix_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_axis_tvalid   = mvalid_reg;
    assign m_axis_tdata    = mdata_reg;
    assign m_axis_tuser[0] = muser_reg;

    // only a newline can start a new result item
    a_nl_only: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tdata != CH_NL) |=> !$rose(m_axis_tvalid))
        else $error("result item raised without newline");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:0]) <= 31'sd900000000 &&
                           $signed(m_axis_tdata[30:0]) >= -31'sd900000000))
        else $error("latitude out of range");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        fn_reg <= 4'(MAX_FIELDS))
        else $error("field count past limit");

    a_gga_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_next && !mvalid_reg && stype_reg == ST_GGA) |-> (fix_next == qual_reg))
        else $error("GGA fix not taken from quality");

endmodule

// ===== verif/nmea_gga_rmc_position_parser_checker.sv =====
`timescale 1ns / 1ps
module nmea_gga_rmc_position_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // latitude[30:0], longitude[62:31], has_fix[63]
    input  logic [0:0]  m_axis_tuser,   // sentence_kind
    output int          errors,
    output int          pending,
    output int          fixes_seen,
    output int          results_seen,
    output logic        in_taken,
    output logic        out_taken
);
    import nggp_pkg::*;

    localparam int FRAC = 5;
    localparam int MAXF = 15;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic               fix;
        logic               kind;
    } position_t;

    position_t position_q[$];

    phase_t      phase;
    stype_t      stype;
    int          hpos, fnum, flen;
    logic        dot, deg_stop;
    logic [7:0]  fchar;
    longint unsigned deg2, deg3;
    longint unsigned mwhole[2], mfrac[2];
    int          fcnt[2], mph[2];
    int          qph;
    logic        qneg, qnz;
    logic        lok;
    longint unsigned ldeg[2], lmin[2];
    logic        stat_a, qual;
    logic signed [31:0] plat, plon, slat, slon;
    logic        sfix;

    function automatic longint unsigned p10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p;
    endfunction

    function automatic logic [7:0] hdr_char(input stype_t t, input int pos);
        string g, r;
        g = "$GPGGA";
        r = "$GPRMC";
        return (t == ST_RMC) ? r[pos] : g[pos];
    endfunction

    task automatic clear_field();
        flen = 0; dot = 0; fchar = 0; deg_stop = 0;
        deg2 = 0; deg3 = 0;
        for (int s = 0; s < 2; s++)
        begin
            mwhole[s] = 0; mfrac[s] = 0; fcnt[s] = 0; mph[s] = 0;
        end
        qph = 0; qneg = 0; qnz = 0;
    endtask

    task automatic feed_min(input int s, input logic [7:0] c);
        longint unsigned w;
        if (mph[s] == 0)
        begin
            if (is_digit(c))
            begin
                w = mwhole[s] * 10 + (c - CH_ZERO);
                mwhole[s] = (w > 65535) ? 65535 : w;
            end
            else if (c == CH_DOT) mph[s] = 1;
            else mph[s] = 2;
        end
        else if (mph[s] == 1)
        begin
            if (is_digit(c))
            begin
                if (fcnt[s] < FRAC)
                begin
                    mfrac[s] = mfrac[s] * 10 + (c - CH_ZERO);
                    fcnt[s]++;
                end
            end
            else mph[s] = 2;
        end
    endtask

    task automatic feed_char(input logic [7:0] c);
        int p;
        p = flen;
        if (p == 0) fchar = c;
        if (flen < 127) flen++;
        if (c == CH_DOT) dot = 1;
        if (p < 3)
        begin
            if (!deg_stop && is_digit(c))
            begin
                if (p < 2) deg2 = deg2 * 10 + (c - CH_ZERO);
                deg3 = deg3 * 10 + (c - CH_ZERO);
            end
            else deg_stop = 1;
        end
        if (p >= 2) feed_min(0, c);
        if (p >= 3) feed_min(1, c);
        if (qph == 0 && is_blank(c))
        begin
        end
        else if (qph == 0 && (c == CH_PLUS || c == CH_MINUS))
        begin
            qneg = (c == CH_MINUS); qph = 1;
        end
        else if (qph < 2 && is_digit(c))
        begin
            qph = 1;
            if (c != CH_ZERO) qnz = 1;
        end
        else qph = 2;
    endtask

    function automatic role_t role_of(input stype_t t, input int f);
        role_t gga[7];
        role_t rmc[7];
        gga = '{R_NONE, R_NONE, R_COORD, R_HLAT, R_COORD, R_HLON, R_QUAL};
        rmc = '{R_NONE, R_NONE, R_STATUS, R_COORD, R_HLAT, R_COORD, R_HLON};
        if (f > 6) return R_NONE;
        return (t == ST_GGA) ? gga[f] : rmc[f];
    endfunction

    function automatic logic signed [31:0] make_coord(input longint unsigned lim);
        logic one, neg;
        int split;
        longint unsigned den, mag;
        one = (flen == 1);
        split = (one && (fchar == CH_UN || fchar == CH_US)) ? 0 : 1;
        neg = one && (fchar == CH_US || fchar == CH_UW);
        den = 60 * p10(FRAC);
        if (!lok) return 0;
        mag = ldeg[split] * 10000000 + (lmin[split] * 10000000 + den / 2) / den;
        if (mag > lim) mag = lim;
        return neg ? -$signed(32'(mag)) : $signed(32'(mag));
    endfunction

    task automatic end_field();
        case (role_of(stype, fnum))
            R_COORD:
            begin
                lok = (flen >= 6) && dot;
                ldeg[0] = deg2;
                ldeg[1] = deg3;
                for (int s = 0; s < 2; s++)
                    lmin[s] = mwhole[s] * p10(FRAC) + mfrac[s] * p10(FRAC - fcnt[s]);
            end
            R_HLAT:   plat = make_coord(900000000);
            R_HLON:   plon = make_coord(1800000000);
            R_QUAL:   qual = qnz && !qneg;
            R_STATUS: stat_a = (flen == 1) && (fchar == CH_UA);
            default:  ;
        endcase
    endtask

    task automatic parse_char(input logic [7:0] c);
        position_t r;
        logic ok;
        if (c == CH_CR) return;
        if (c == CH_NL)
        begin
            if (phase == PH_BODY && fnum >= 7)
            begin
                if (stype == ST_GGA)
                begin
                    slat = plat; slon = plon; sfix = qual;
                end
                else if (stat_a)
                begin
                    slat = plat; slon = plon; sfix = 1;
                end
                else sfix = 0;
                r.lat = slat[30:0];
                r.lon = slon;
                r.fix = sfix;
                r.kind = (stype == ST_RMC);
                position_q.push_back(r);
            end
            phase = PH_START;
            return;
        end
        case (phase)
            PH_START:
            begin
                if (!is_blank(c))
                begin
                    if (c == CH_DOLLAR)
                    begin
                        phase = PH_HEADER; hpos = 1; stype = ST_NONE;
                    end
                    else phase = PH_SKIP;
                end
            end
            PH_HEADER:
            begin
                if (hpos == 3)
                begin
                    if (c == CH_UG) stype = ST_GGA;
                    else if (c == CH_UR) stype = ST_RMC;
                    ok = (stype != ST_NONE);
                end
                else if (hpos < 3) ok = (c == hdr_char(ST_GGA, hpos));
                else ok = (hpos < 6) && (stype != ST_NONE) && (c == hdr_char(stype, hpos));
                if (!ok) phase = PH_SKIP;
                else
                begin
                    hpos++;
                    if (hpos >= 6)
                    begin
                        phase = PH_BODY; fnum = 0; clear_field();
                    end
                end
            end
            PH_BODY:
            begin
                if (fnum < MAXF)
                begin
                    if (c == CH_COMMA || c == CH_STAR)
                    begin
                        end_field(); fnum++; clear_field();
                    end
                    else feed_char(c);
                end
            end
            default: ;
        endcase
    endtask

    initial
    begin
        phase = PH_START; stype = ST_NONE; hpos = 0; fnum = 0;
        clear_field();
        lok = 0; ldeg = '{0, 0}; lmin = '{0, 0};
        stat_a = 0; qual = 0; plat = 0; plon = 0; slat = 0; slon = 0; sfix = 0;
        errors = 0; fixes_seen = 0; results_seen = 0;
    end

    assign pending = position_q.size();

    // sample mid-cycle: handshake at the next rising edge is already settled
    always @(negedge clk)
    begin
        position_t e, a;
        in_taken  = rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_taken) parse_char(s_axis_tdata);
        if (out_taken)
        begin
            a.lat = m_axis_tdata[30:0];
            a.lon = m_axis_tdata[62:31];
            a.fix = m_axis_tdata[63];
            a.kind = m_axis_tuser[0];
            results_seen++;
            if (a.fix) fixes_seen++;
            if (position_q.size() == 0)
            begin
                $display("%0t: unexpected result lat=%0d lon=%0d fix=%0b kind=%0b",
                         $time, a.lat, a.lon, a.fix, a.kind);
                errors++;
            end
            else
            begin
                e = position_q.pop_front();
                if (e.lat !== a.lat)
                begin
                    $display("%0t: latitude expected %0d actual %0d", $time, e.lat, a.lat);
                    errors++;
                end
                if (e.lon !== a.lon)
                begin
                    $display("%0t: longitude expected %0d actual %0d", $time, e.lon, a.lon);
                    errors++;
                end
                if (e.fix !== a.fix)
                begin
                    $display("%0t: has_fix expected %0b actual %0b", $time, e.fix, a.fix);
                    errors++;
                end
                if (e.kind !== a.kind)
                begin
                    $display("%0t: sentence_kind expected %0b actual %0b",
                             $time, e.kind, a.kind);
                    errors++;
                end
            end
        end
    end
endmodule

// ===== verif/nmea_gga_rmc_position_parser_tb.sv =====
`timescale 1ns / 1ps
module nmea_gga_rmc_position_parser_tb;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // latitude[30:0], longitude[62:31], has_fix[63]
    logic [0:0]  m_axis_tuser;   // sentence_kind

    int   errors, pending, fixes_seen, results_seen;
    logic in_taken, out_taken;
    int   bytes_sent, idle_cnt, stall_cnt;
    logic no_idle;
    byte  line_q[$];

    nmea_gga_rmc_position_parser dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    nmea_gga_rmc_position_parser_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .errors(errors), .pending(pending), .fixes_seen(fixes_seen),
        .results_seen(results_seen), .in_taken(in_taken), .out_taken(out_taken)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver: random stall after each taken item
    always @(posedge clk)
    begin
        if (!rst_n) m_axis_tready <= 0;
        else
        begin
            if (out_taken) stall_cnt = no_idle ? 0 : $urandom_range(0, 5);
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_axis_tready <= 0;
            end
            else m_axis_tready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (in_taken || out_taken) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no traffic", $time);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++) line_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    task automatic add_coord(input int degw);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return;
        if (k == 1)
        begin
            add_str("12.3");
            return;
        end
        if (k == 2)
        begin
            add_digits(degw + 4);
            return;
        end
        if (k == 3)
        begin
            add_digits($urandom_range(1, 8));
            add_str(".");
            add_digits($urandom_range(0, 9));
            return;
        end
        if (k == 4)
            add_digits(degw);
        else if (degw == 2)
            add_str($sformatf("%02d", $urandom_range(0, 90)));
        else
            add_str($sformatf("%03d", $urandom_range(0, 180)));
        add_str($sformatf("%02d", $urandom_range(0, (k == 5) ? 99 : 59)));
        add_str(".");
        add_digits($urandom_range(0, 7));
    endtask

    task automatic add_pick(input int which);
        string hem[8];
        string qs[10];
        string st[4];
        hem = '{"N", "S", "E", "W", "", "X", "NN", "s"};
        qs = '{"0", "1", "2", "-1", "+3", " 0", " 7", "", "00", "05"};
        st = '{"A", "V", "", "AA"};
        case (which)
            0: add_str(hem[$urandom_range(0, 7)]);
            1: add_str(qs[$urandom_range(0, 9)]);
            default: add_str(st[$urandom_range(0, 3)]);
        endcase
    endtask

    task automatic build_sentence(input logic rmc);
        int extra;
        if ($urandom_range(0, 4) == 0) add_str(" \t");
        add_str(rmc ? "$GPRMC," : "$GPGGA,");
        add_digits(6);
        add_str(",");
        if (rmc)
        begin
            add_pick(2);
            add_str(",");
        end
        add_coord(2);
        add_str(",");
        add_pick(0);
        add_str(",");
        add_coord(3);
        add_str(",");
        add_pick(0);
        add_str(",");
        if (!rmc) add_pick(1);
        extra = $urandom_range(0, 12);
        for (int i = 0; i < extra; i++)
        begin
            add_str(",");
            add_digits($urandom_range(0, 3));
        end
        add_str("*4");
        add_digits(1);
        add_str("\r\n");
    endtask

    task automatic build_random_line();
        int k, n;
        k = $urandom_range(0, 99);
        if (k < 40) build_sentence(0);
        else if (k < 75) build_sentence(1);
        else if (k < 90)
        begin
            build_sentence($urandom_range(0, 1));
            // corrupt one to three characters before the final newline with random bytes
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                line_q[$urandom_range(0, line_q.size() - 2)] = 8'($urandom_range(0, 255));
        end
        else
        begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(8'h0A);
        end
    endtask

    // entered and left at a rising edge; valid stays high across back-to-back items
    task automatic send_byte(input byte b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        while (line_q.size() > 0) send_byte(line_q.pop_front());
    endtask

    initial
    begin
        string directed[14];
        directed = '{
            "$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
            "  \t\v\f$GPRMC,123519,A,9959.99999,S,99999.99999,W,022.4,084.4,230394*6A\n",
            "$GPGGA,000000,0000.00000,N,00000.00000,E,0,00*00\n",
            "$GPGGAxyz,1,9000.0000,S,18000.0000,W, +2,1*00\n",
            "$GPRMC,1,V,4807.038,N,01131.000,E,0*00\n",
            "$GPRMC,1,A,4807,N,011.3,E,0*00\n",
            "$GPGGA,1,12.4,Q,4807.123,X,-1,1*00\n",
            "$GPGGA,1,4807.03812345,N,01131.5,EE,+0,1\r*00\n",
            "$GPGGA,1,48+7.1,N,1.2.3.4,E,07,1\n",
            "$GPRMC,1,A,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17\n",
            "$GPGGA,1,2,3,4\n",
            "$GPGGA,1,4807.038,N,01131.000,E,1,$GPRMC,1,A\n",
            "$GPGSV,1,2,3,4,5,6,7,8\nxyz\n",
            "$GPRMC,1,A,0000.0000,N,0000.0000,W,0*00\n"
        };
        rst_n <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata <= 0;
        m_axis_tready <= 0;
        no_idle = 0;
        bytes_sent = 0;
        idle_cnt = 0;
        stall_cnt = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[i])
        begin
            add_str(directed[i]);
            send_line();
        end
        // hold off until the output side has drained
        s_axis_tvalid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        while (bytes_sent < 1600)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            build_random_line();
            send_line();
        end
        s_axis_tvalid <= 0;
        no_idle = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d characters in GGA, RMC and noise lines with random gaps;",
                 bytes_sent);
        $display("checked %0d position results, %0d of them with a fix.",
                 results_seen, fixes_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/nggp_pkg.sv
hw/rtl/nggp_min_acc.sv
hw/rtl/nggp_coord.sv
hw/rtl/nmea_gga_rmc_position_parser.sv
verif/nmea_gga_rmc_position_parser_checker.sv
verif/nmea_gga_rmc_position_parser_tb.sv
